### hw/rtl/fdfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Format-driven field scanner package
// Shared constants, codes and controller/datapath handshake structures.
// ----------------------------------------------------------------------------
package fdfs_pkg;

   localparam int FORMAT_MAX = 8;
   localparam int FORMAT_W   = 8 * FORMAT_MAX;
   localparam int LEN_W      = 4;
   localparam int POS_W      = $clog2(FORMAT_MAX + 1);
   localparam int IDX_W      = $clog2(FORMAT_MAX);
   localparam int CSR_IDX_W  = 1;
   localparam int MAX_RESULTS = 4;
   localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_CHARS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_LENGTH = 1'd1;

   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_D       = 8'h64;
   localparam logic [7:0] CHR_X       = 8'h78;
   localparam logic [7:0] CHR_C       = 8'h63;
   localparam logic [7:0] CHR_S       = 8'h73;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_TAB     = 8'd9;
   localparam logic [7:0] CHR_NL      = 8'd10;
   localparam logic [7:0] CHR_MINUS   = 8'h2d;
   localparam logic [7:0] CHR_PLUS    = 8'h2b;
   localparam logic [7:0] CHR_0       = 8'h30;
   localparam logic [7:0] CHR_9       = 8'h39;
   localparam logic [7:0] CHR_LA      = 8'h61;
   localparam logic [7:0] CHR_LF      = 8'h66;
   localparam logic [7:0] CHR_UA      = 8'h41;
   localparam logic [7:0] CHR_UF      = 8'h46;

   typedef enum logic [2:0] {
      KIND_DEC     = 3'd0,
      KIND_HEX     = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_STR     = 3'd3,
      KIND_STR_END = 3'd4,
      KIND_COUNT   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_DISPATCH = 3'd0,
      PH_DEC_WS   = 3'd1,
      PH_DEC_DIG  = 3'd2,
      PH_HEX_WS   = 3'd3,
      PH_HEX_DIG  = 3'd4,
      PH_STR_WS   = 3'd5,
      PH_STR_COPY = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_WALK   = 3'd1,
      ST_FINISH = 3'd2,
      ST_COUNT  = 3'd3,
      ST_FLUSH  = 3'd4
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic count;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic last;
      logic step_emits;
      logic finish_emits;
      logic count_emits;
      logic push_ok;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/fdfs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one text byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
interface fdfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/fdfs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one scanner result.
// ----------------------------------------------------------------------------
interface fdfs_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_kind;
   logic [2:0]         out_arg;
   logic signed [31:0] out_value;
   logic               out_last;

   modport source (output valid, output out_kind, output out_arg, output out_value,
                   output out_last, input ready);
   modport sink   (input valid, input out_kind, input out_arg, input out_value,
                   input out_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/fdfs_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fdfs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fdfs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fdfs_pkg::FORMAT_W-1:0]   csr_data;

   modport source (output valid, output csr_index, output csr_data, input ready);
   modport sink   (input valid, input csr_index, input csr_data, output ready);
endinterface
`default_nettype wire

### hw/rtl/fdfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner controller
// Sequences the format walk, final completion, count and result flush.
// ----------------------------------------------------------------------------
module fdfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fdfs_pkg::status_type status,
   output fdfs_pkg::cmd_type    cmd
);
   import fdfs_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = status.last ? ST_FINISH : ST_FLUSH;
            end else if (!status.step_emits || status.push_ok) begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.finish_emits || status.push_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (!status.count_emits || status.push_ok) begin
               cmd.count = 1'b1;
               state_in  = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hw/rtl/fdfs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner datapath
// Format registers, scan state, one walk step per command, result staging.
// ----------------------------------------------------------------------------
module fdfs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fdfs_pkg::cmd_type    cmd,
   output fdfs_pkg::status_type status,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   fdfs_csr_if.sink             csr_if,
   fdfs_rsp_if.source           rsp_if
);
   import fdfs_pkg::*;

   logic [FORMAT_MAX-1:0][7:0] fmt_ff;
   logic [LEN_W-1:0]           len_ff;

   logic [POS_W-1:0] pos_ff;
   phase_type        phase_ff;
   logic [31:0]      acc_ff;
   logic             neg_ff;
   logic [2:0]       argc_ff;
   logic             exh_ff;
   logic             consumed_ff;
   logic [CNT_W-1:0] n_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic             pend_valid_ff;
   kind_type         pend_kind_ff;
   logic [2:0]       pend_arg_ff;
   logic [31:0]      pend_value_ff;

   logic             out_valid_ff;
   kind_type         out_kind_ff;
   logic [2:0]       out_arg_ff;
   logic [31:0]      out_value_ff;
   logic             out_last_ff;

   logic [POS_W-1:0] lim;
   logic [POS_W-1:0] fend;
   logic [POS_W-1:0] pos_p1;
   logic [7:0]       fc;
   logic [7:0]       fs;
   logic             is_ws;
   logic             is_dig;
   logic             is_hex;
   logic [3:0]       hex_val;
   logic [31:0]      num_val;
   logic [31:0]      acc_dec;
   logic [31:0]      acc_hex;
   logic [31:0]      byte_val;

   phase_type        s_phase;
   logic [POS_W-1:0] s_pos;
   logic [31:0]      s_acc;
   logic             s_neg;
   logic [2:0]       s_argc;
   logic             s_exh;
   logic             s_consumed;
   logic             s_emit;
   kind_type         s_kind;
   logic [31:0]      s_value;

   logic             f_emit;
   kind_type         f_kind;
   logic [31:0]      f_value;

   logic             room;
   logic             emit_fire;
   kind_type         e_kind;
   logic [31:0]      e_value;

   always_comb begin
      lim = (len_ff > LEN_W'(FORMAT_MAX)) ? POS_W'(FORMAT_MAX) : POS_W'(len_ff);
      fend = lim;
      for (int k = FORMAT_MAX - 1; k >= 0; k--) begin
         if ((POS_W'(k) < lim) && (fmt_ff[k] == 8'h00)) begin
            fend = POS_W'(k);
         end
      end
   end

   assign pos_p1   = pos_ff + POS_W'(1);
   assign fc       = fmt_ff[pos_ff[IDX_W-1:0]];
   assign fs       = fmt_ff[pos_p1[IDX_W-1:0]];
   assign is_ws    = (byte_ff == CHR_SPACE) || (byte_ff == CHR_TAB) || (byte_ff == CHR_NL);
   assign is_dig   = (byte_ff >= CHR_0) && (byte_ff <= CHR_9);
   assign byte_val = {24'd0, byte_ff};
   assign num_val  = neg_ff ? (32'd0 - acc_ff) : acc_ff;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (is_dig) begin
         hex_val = 4'(byte_ff - CHR_0);
      end else if ((byte_ff >= CHR_LA) && (byte_ff <= CHR_LF)) begin
         hex_val = 4'(byte_ff - CHR_LA + 8'd10);
      end else if ((byte_ff >= CHR_UA) && (byte_ff <= CHR_UF)) begin
         hex_val = 4'(byte_ff - CHR_UA + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign acc_dec = (acc_ff << 3) + (acc_ff << 1) + {28'd0, hex_val};
   assign acc_hex = (acc_ff << 4) + {28'd0, hex_val};

   always_comb begin
      s_phase    = phase_ff;
      s_pos      = pos_ff;
      s_acc      = acc_ff;
      s_neg      = neg_ff;
      s_argc     = argc_ff;
      s_exh      = exh_ff;
      s_consumed = consumed_ff;
      s_emit     = 1'b0;
      s_kind     = KIND_DEC;
      s_value    = 32'd0;
      unique case (phase_ff)
         PH_DEC_WS, PH_DEC_DIG, PH_HEX_WS, PH_HEX_DIG: begin
            if ((phase_ff == PH_DEC_WS || phase_ff == PH_HEX_WS) && is_ws) begin
               s_consumed = 1'b1;
            end else if (phase_ff == PH_DEC_WS &&
                         (byte_ff == CHR_MINUS || byte_ff == CHR_PLUS)) begin
               s_neg      = (byte_ff == CHR_MINUS);
               s_phase    = PH_DEC_DIG;
               s_consumed = 1'b1;
            end else if ((phase_ff == PH_DEC_WS || phase_ff == PH_DEC_DIG) && is_dig) begin
               s_acc      = acc_dec;
               s_phase    = PH_DEC_DIG;
               s_consumed = 1'b1;
            end else if ((phase_ff == PH_HEX_WS || phase_ff == PH_HEX_DIG) && is_hex) begin
               s_acc      = acc_hex;
               s_phase    = PH_HEX_DIG;
               s_consumed = 1'b1;
            end else begin
               s_emit  = 1'b1;
               s_kind  = (phase_ff == PH_HEX_WS || phase_ff == PH_HEX_DIG) ?
                         KIND_HEX : KIND_DEC;
               s_value = num_val;
               s_argc  = argc_ff + 3'd1;
               s_phase = PH_DISPATCH;
               s_acc   = 32'd0;
               s_neg   = 1'b0;
            end
         end
         PH_STR_WS: begin
            if (!is_ws) begin
               s_emit  = 1'b1;
               s_kind  = KIND_STR;
               s_value = byte_val;
               s_phase = PH_STR_COPY;
            end
            s_consumed = 1'b1;
         end
         PH_STR_COPY: begin
            s_emit = 1'b1;
            if (is_ws) begin
               s_kind  = KIND_STR_END;
               s_argc  = argc_ff + 3'd1;
               s_phase = PH_DISPATCH;
            end else begin
               s_kind     = KIND_STR;
               s_value    = byte_val;
               s_consumed = 1'b1;
            end
         end
         default: begin
            s_phase = PH_DISPATCH;
            if (pos_ff >= fend) begin
               s_exh = 1'b1;
            end else if (fc == CHR_PERCENT) begin
               if (pos_p1 >= fend) begin
                  s_pos = fend;
               end else begin
                  s_pos = pos_ff + POS_W'(2);
                  s_acc = 32'd0;
                  s_neg = 1'b0;
                  if (fs == CHR_D) begin
                     s_phase = PH_DEC_WS;
                  end else if (fs == CHR_X) begin
                     s_phase = PH_HEX_WS;
                  end else if (fs == CHR_S) begin
                     s_phase = PH_STR_WS;
                  end else if (fs == CHR_C) begin
                     s_emit     = 1'b1;
                     s_kind     = KIND_CHAR;
                     s_value    = byte_val;
                     s_argc     = argc_ff + 3'd1;
                     s_consumed = 1'b1;
                  end
               end
            end else begin
               if (byte_ff == fc) begin
                  s_consumed = 1'b1;
               end
               s_pos = pos_p1;
            end
         end
      endcase
   end

   always_comb begin
      f_emit  = 1'b1;
      f_kind  = KIND_DEC;
      f_value = num_val;
      unique case (phase_ff)
         PH_DEC_WS, PH_DEC_DIG: begin
            f_kind = KIND_DEC;
         end
         PH_HEX_WS, PH_HEX_DIG: begin
            f_kind = KIND_HEX;
         end
         PH_STR_WS, PH_STR_COPY: begin
            f_kind  = KIND_STR_END;
            f_value = 32'd0;
         end
         default: begin
            f_emit = 1'b0;
         end
      endcase
   end

   assign room      = (n_ff < CNT_W'(MAX_RESULTS));
   assign emit_fire = room && ((cmd.step && s_emit) || (cmd.finish && f_emit) || cmd.count);

   always_comb begin
      e_kind  = KIND_COUNT;
      e_value = 32'd0;
      if (cmd.step) begin
         e_kind  = s_kind;
         e_value = s_value;
      end else if (cmd.finish) begin
         e_kind  = f_kind;
         e_value = f_value;
      end
   end

   assign status.walk_done    = consumed_ff || exh_ff;
   assign status.last         = last_ff;
   assign status.step_emits   = s_emit && room;
   assign status.finish_emits = f_emit && room;
   assign status.count_emits  = room;
   assign status.push_ok      = !pend_valid_ff || !out_valid_ff || rsp_if.ready;
   assign status.pend_valid   = pend_valid_ff;
   assign status.out_free     = !out_valid_ff || rsp_if.ready;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= '0;
         len_ff        <= '0;
         pos_ff        <= '0;
         phase_ff      <= PH_DISPATCH;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         argc_ff       <= '0;
         exh_ff        <= 1'b0;
         consumed_ff   <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            unique case (csr_if.csr_index)
               CSR_FORMAT_CHARS: begin
                  fmt_ff <= csr_if.csr_data;
               end
               CSR_FORMAT_LENGTH: begin
                  len_ff <= csr_if.csr_data[LEN_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (cmd.load) begin
            consumed_ff <= 1'b0;
            n_ff        <= '0;
         end else if (cmd.step) begin
            pos_ff      <= s_pos;
            phase_ff    <= s_phase;
            acc_ff      <= s_acc;
            neg_ff      <= s_neg;
            argc_ff     <= s_argc;
            exh_ff      <= s_exh;
            consumed_ff <= s_consumed;
         end else if (cmd.finish && f_emit) begin
            argc_ff  <= argc_ff + 3'd1;
            phase_ff <= PH_DISPATCH;
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
         end else if (cmd.count) begin
            pos_ff   <= '0;
            phase_ff <= PH_DISPATCH;
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
            argc_ff  <= '0;
            exh_ff   <= 1'b0;
         end

         if (emit_fire) begin
            n_ff <= n_ff + CNT_W'(1);
         end

         if (emit_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end

         if ((cmd.flush || emit_fire) && pend_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
      if (emit_fire) begin
         pend_kind_ff  <= e_kind;
         pend_arg_ff   <= argc_ff;
         pend_value_ff <= e_value;
      end
      if ((cmd.flush || emit_fire) && pend_valid_ff) begin
         out_kind_ff  <= pend_kind_ff;
         out_arg_ff   <= pend_arg_ff;
         out_value_ff <= pend_value_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_kind  = out_kind_ff;
   assign rsp_if.out_arg   = out_arg_ff;
   assign rsp_if.out_value = out_value_ff;
   assign rsp_if.out_last  = out_last_ff;

endmodule
`default_nettype wire

### hw/rtl/format_driven_field_scanner_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Format-driven field scanner
// Parses a byte stream against a configured scanf-style format.
// ----------------------------------------------------------------------------
// Each accepted byte is loaded and walked: one step per format element
// dispatched and one per conversion step that takes or ends a field; the last
// byte adds a completion and a count, and each byte ends with a flush. A step,
// completion or count that emits waits while the two-entry result staging
// (pending plus output) is full. A result goes out at the next push or flush.
// Synchronous reset clears the format registers and all scanning state.
// ----------------------------------------------------------------------------
module format_driven_field_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   fdfs_req_if.sink   req_if,
   fdfs_rsp_if.source rsp_if,
   fdfs_csr_if.sink   csr_if
);
   import fdfs_pkg::*;

   cmd_type    cmd;
   status_type status;

   fdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fdfs_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .in_byte (req_if.in_byte),
      .in_last (req_if.in_last),
      .csr_if  (csr_if),
      .rsp_if  (rsp_if)
   );

endmodule
`default_nettype wire

### tb/sv/format_driven_field_scanner_unit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Format-driven field scanner checker
// Watches the byte, result and configuration channels of the scanner. It keeps
// its own copy of the format registers and the scanning state, works out the
// results each accepted byte must cause, and compares every accepted result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module format_driven_field_scanner_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_byte,
   input  logic                            req_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [2:0]                      rsp_kind,
   input  logic [2:0]                      rsp_arg,
   input  logic signed [31:0]              rsp_value,
   input  logic                            rsp_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fdfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdfs_pkg::FORMAT_W-1:0]   csr_data,
   output int                              failure_count,
   output int                              pending_count,
   output int                              results_checked
);
   import fdfs_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         arg;
      logic signed [31:0] value;
      logic               last;
   } scan_result_type;

   logic [FORMAT_W-1:0] fmt_chars;
   logic [LEN_W-1:0]    fmt_len;
   logic [3:0]          scan_pos;
   phase_type           phase;
   logic [31:0]         accum;
   logic                neg;
   logic [2:0]          arg_count;
   logic                exhausted;

   scan_result_type expected_results[$];
   scan_result_type step_results[MAX_RESULTS];
   int              step_count;
   int              fail_tally;
   int              checked_tally;
   int              reported;

   function automatic logic [7:0] fmt_byte(input int k);
      return fmt_chars[k[2:0] * 8 +: 8];
   endfunction

   function automatic bit is_space(input logic [7:0] b);
      return b == CHR_SPACE || b == CHR_TAB || b == CHR_NL;
   endfunction

   function automatic int hex_value(input logic [7:0] b);
      if (b >= CHR_0 && b <= CHR_9) return b - CHR_0;
      if (b >= CHR_LA && b <= CHR_LF) return b - CHR_LA + 10;
      if (b >= CHR_UA && b <= CHR_UF) return b - CHR_UA + 10;
      return -1;
   endfunction

   task add_result(input kind_type kind, input logic [31:0] value);
      if (step_count < MAX_RESULTS) begin
         step_results[step_count].kind  = kind;
         step_results[step_count].arg   = arg_count;
         step_results[step_count].value = value;
         step_results[step_count].last  = 1'b0;
         step_count++;
      end
   endtask

   task close_number(input kind_type kind);
      add_result(kind, neg ? -accum : accum);
      arg_count++;
      phase = PH_DISPATCH;
      accum = '0;
      neg   = 1'b0;
   endtask

   task close_string();
      add_result(KIND_STR_END, '0);
      arg_count++;
      phase = PH_DISPATCH;
   endtask

   task clear_scan();
      scan_pos  = '0;
      phase     = PH_DISPATCH;
      accum     = '0;
      neg       = 1'b0;
      arg_count = '0;
      exhausted = 1'b0;
   endtask

   task scan_byte(input logic [7:0] b, input logic last);
      bit         consumed;
      bit         dig;
      int         h;
      int         lim;
      int         fend;
      logic [7:0] c;
      logic [7:0] s;
      consumed   = 1'b0;
      step_count = 0;
      while (!consumed && !exhausted) begin
         h   = hex_value(b);
         dig = (b >= CHR_0 && b <= CHR_9);
         case (phase)
            PH_DEC_WS: begin
               if (is_space(b)) begin
                  consumed = 1'b1;
               end else if (b == CHR_MINUS || b == CHR_PLUS) begin
                  neg      = (b == CHR_MINUS);
                  phase    = PH_DEC_DIG;
                  consumed = 1'b1;
               end else if (dig) begin
                  accum    = accum * 10 + h;
                  phase    = PH_DEC_DIG;
                  consumed = 1'b1;
               end else begin
                  close_number(KIND_DEC);
               end
            end
            PH_DEC_DIG: begin
               if (dig) begin
                  accum    = accum * 10 + h;
                  consumed = 1'b1;
               end else begin
                  close_number(KIND_DEC);
               end
            end
            PH_HEX_WS: begin
               if (is_space(b)) begin
                  consumed = 1'b1;
               end else if (h >= 0) begin
                  accum    = accum * 16 + h;
                  phase    = PH_HEX_DIG;
                  consumed = 1'b1;
               end else begin
                  close_number(KIND_HEX);
               end
            end
            PH_HEX_DIG: begin
               if (h >= 0) begin
                  accum    = accum * 16 + h;
                  consumed = 1'b1;
               end else begin
                  close_number(KIND_HEX);
               end
            end
            PH_STR_WS: begin
               if (!is_space(b)) begin
                  add_result(KIND_STR, {24'd0, b});
                  phase = PH_STR_COPY;
               end
               consumed = 1'b1;
            end
            PH_STR_COPY: begin
               if (is_space(b)) begin
                  close_string();
               end else begin
                  add_result(KIND_STR, {24'd0, b});
                  consumed = 1'b1;
               end
            end
            default: begin
               lim  = (fmt_len > FORMAT_MAX) ? FORMAT_MAX : fmt_len;
               fend = 0;
               while (fend < lim && fmt_byte(fend) != 8'd0) fend++;
               phase = PH_DISPATCH;
               if (scan_pos >= fend) begin
                  exhausted = 1'b1;
               end else begin
                  c = fmt_byte(scan_pos);
                  if (c == CHR_PERCENT) begin
                     if (scan_pos + 1 >= fend) begin
                        scan_pos = 4'(fend);
                     end else begin
                        s        = fmt_byte(scan_pos + 1);
                        scan_pos = 4'(scan_pos + 2);
                        accum    = '0;
                        neg      = 1'b0;
                        case (s)
                           CHR_D: phase = PH_DEC_WS;
                           CHR_X: phase = PH_HEX_WS;
                           CHR_S: phase = PH_STR_WS;
                           CHR_C: begin
                              add_result(KIND_CHAR, {24'd0, b});
                              arg_count++;
                              consumed = 1'b1;
                           end
                           default: ;
                        endcase
                     end
                  end else begin
                     if (b == c) consumed = 1'b1;
                     scan_pos = 4'(scan_pos + 1);
                  end
               end
            end
         endcase
      end

      if (last) begin
         if (phase == PH_DEC_WS || phase == PH_DEC_DIG) begin
            close_number(KIND_DEC);
         end else if (phase == PH_HEX_WS || phase == PH_HEX_DIG) begin
            close_number(KIND_HEX);
         end else if (phase == PH_STR_WS || phase == PH_STR_COPY) begin
            close_string();
         end
         add_result(KIND_COUNT, '0);
         clear_scan();
      end

      if (step_count > 0) step_results[step_count - 1].last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_results.push_back(step_results[i]);
   endtask

   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         fmt_chars = '0;
         fmt_len   = '0;
         clear_scan();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FORMAT_CHARS) begin
               fmt_chars = csr_data;
            end else if (csr_index == CSR_FORMAT_LENGTH) begin
               fmt_len = csr_data[LEN_W-1:0];
            end
         end
         if (req_valid && req_ready) scan_byte(req_byte, req_last);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_tally++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected result: kind %0d arg %0d value %0d last %0d",
                           rsp_kind, rsp_arg, rsp_value, rsp_last);
               end
            end else begin
               want = expected_results.pop_front();
               checked_tally++;
               if (rsp_kind !== want.kind || rsp_arg !== want.arg ||
                   rsp_value !== want.value || rsp_last !== want.last) begin
                  fail_tally++;
                  if (reported < 10) begin
                     reported++;
                     $display("result mismatch: expected kind %0d arg %0d value %0d last %0d",
                              want.kind, want.arg, $signed(want.value), want.last);
                     $display("                 got      kind %0d arg %0d value %0d last %0d",
                              rsp_kind, rsp_arg, rsp_value, rsp_last);
                  end
               end
            end
         end
      end
      failure_count   <= fail_tally;
      pending_count   <= expected_results.size();
      results_checked <= checked_tally;
   end

endmodule
`default_nettype wire

### tb/sv/format_driven_field_scanner_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Format-driven field scanner testbench
// Drives text bytes and format settings into the scanner and leaves all result
// checking to the checker beside it. A short directed part walks the special
// cases of the format walk; the random part mostly sends text shaped after the
// configured format, with noise, corrupted bytes and random formats mixed in.
// ----------------------------------------------------------------------------
module format_driven_field_scanner_unit_test;
   import fdfs_pkg::*;

   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 460;

   logic clock;
   logic reset;
   logic no_idle;

   fdfs_req_if req_if ();
   fdfs_rsp_if rsp_if ();
   fdfs_csr_if csr_if ();

   int failure_count;
   int pending_count;
   int results_checked;
   int quiet_cycles;
   int bytes_sent;
   int buffers_sent;
   int format_settings;

   logic [7:0] text_q[$];

   format_driven_field_scanner_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   format_driven_field_scanner_unit_checker scan_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_byte        (req_if.in_byte),
      .req_last        (req_if.in_last),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_kind        (rsp_if.out_kind),
      .rsp_arg         (rsp_if.out_arg),
      .rsp_value       (rsp_if.out_value),
      .rsp_last        (rsp_if.out_last),
      .csr_valid       (csr_if.valid),
      .csr_ready       (csr_if.ready),
      .csr_index       (csr_if.csr_index),
      .csr_data        (csr_if.csr_data),
      .failure_count   (failure_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 23);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL format_driven_field_scanner_unit");
            $finish;
         end
      end
   end

   function automatic logic [63:0] pack_format(input string f);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < f.len() && i < 8; i++) r[i * 8 +: 8] = f[i];
      return r;
   endfunction

   function automatic logic [7:0] any_space();
      case ($urandom_range(0, 2))
         0:       return CHR_SPACE;
         1:       return CHR_TAB;
         default: return CHR_NL;
      endcase
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(CHR_0 + v);
      return 8'(($urandom_range(0, 1) ? CHR_LA : CHR_UA) + v - 10);
   endfunction

   function automatic string random_format();
      string pool[11];
      string f;
      string el;
      pool = '{"%d", "%x", "%c", "%s", ",", ":", " ", "%%", "%q", "a", "-"};
      f = "";
      for (int k = 0; k < 8; k++) begin
         el = pool[$urandom_range(0, 10)];
         if (f.len() + el.len() > 8) break;
         f = {f, el};
         if (f.len() >= 2 && $urandom_range(0, 4) == 0) break;
      end
      return f;
   endfunction

   task set_format(input logic [63:0] chars, input logic [3:0] len);
      csr_if.valid     <= 1'b1;
      csr_if.csr_index <= CSR_FORMAT_CHARS;
      csr_if.csr_data  <= chars;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.csr_index <= CSR_FORMAT_LENGTH;
      csr_if.csr_data  <= {60'd0, len};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      format_settings++;
   endtask

   task send_byte(input logic [7:0] b, input logic last);
      if (!no_idle && $urandom_range(0, 99) < 23) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      if (last) buffers_sent++;
   endtask

   task send_str(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
   endtask

   task send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task build_text(input logic [63:0] chars, input logic [3:0] len);
      int         lim;
      int         fend;
      int         k;
      int         n;
      logic [7:0] c;
      logic [7:0] s;
      text_q.delete();
      lim  = (len > 8) ? 8 : len;
      fend = 0;
      while (fend < lim && chars[fend * 8 +: 8] != 8'd0) fend++;
      k = 0;
      while (k < fend) begin
         c = chars[k * 8 +: 8];
         if (c == CHR_PERCENT && k + 1 < fend) begin
            s = chars[(k + 1) * 8 +: 8];
            k += 2;
            case (s)
               CHR_D, CHR_X: begin
                  repeat (text_q.size() > 0 ? $urandom_range(1, 2) : $urandom_range(0, 2))
                     text_q.push_back(any_space());
                  if (s == CHR_D && $urandom_range(0, 9) < 3)
                     text_q.push_back($urandom_range(0, 1) ? CHR_MINUS : CHR_PLUS);
                  n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
                  repeat (n) text_q.push_back(s == CHR_D ? 8'(CHR_0 + $urandom_range(0, 9))
                                                         : hex_char());
               end
               CHR_C: text_q.push_back(8'($urandom_range(0, 255)));
               CHR_S: begin
                  repeat ($urandom_range(0, 1)) text_q.push_back(any_space());
                  repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(33, 126)));
                  text_q.push_back(any_space());
               end
               default: ;
            endcase
         end else begin
            text_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : c);
            k++;
         end
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      string       f;
      logic [63:0] chars;
      logic [3:0]  len;
      int          random_base;
      int          spent;

      reset            = 1'b1;
      no_idle          = 1'b0;
      req_if.valid     = 1'b0;
      req_if.in_byte   = 8'd0;
      req_if.in_last   = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.csr_index = CSR_FORMAT_CHARS;
      csr_if.csr_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Empty format straight after reset: every byte is ignored until the last one.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();

      set_format(pack_format("%d,%x"), 4'd5);
      send_str(" -4,aF", 1'b1);
      settle();

      // Four empty conversions on one final byte leave no room for the count.
      set_format(pack_format("%d%d%d%d"), 4'd8);
      send_str("z", 1'b1);
      settle();

      set_format(pack_format("%d"), 4'd2);
      send_str("-", 1'b1);
      settle();

      set_format(pack_format("ab%"), 4'd3);
      send_str("abc", 1'b1);
      settle();

      // A zero byte inside the length cuts the format short.
      set_format(pack_format("%c") | (pack_format("%d") << 24), 4'd8);
      send_str("Kq", 1'b1);
      settle();

      set_format(pack_format("%c%c%c%c"), 4'd15);
      send_str("ab", 1'b1);
      settle();

      set_format(pack_format("%s%c"), 4'd4);
      send_str("x y", 1'b1);
      settle();

      set_format(pack_format("%%%q%c"), 4'd6);
      send_str("#", 1'b1);
      settle();

      set_format('1, 4'd8);
      send_byte(8'hFF, 1'b1);
      settle();

      // The format changes while a buffer is half scanned.
      set_format(pack_format("%d%d"), 4'd4);
      send_str("12 ", 1'b0);
      settle();
      set_format(pack_format("%x%c"), 4'd4);
      send_str("7f", 1'b1);
      settle();

      random_base = bytes_sent;
      while (bytes_sent - random_base < RANDOM_BYTES) begin
         spent = bytes_sent - random_base;
         no_idle <= (spent >= 180 && spent < 300);
         if ($urandom_range(0, 99) < 80) begin
            f     = random_format();
            chars = pack_format(f);
            len   = 4'(f.len());
         end else begin
            chars = {$urandom, $urandom};
            len   = 4'($urandom_range(0, 15));
         end
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0:       len = 4'd0;
               1:       len = 4'd8;
               default: len = 4'd15;
            endcase
         end
         set_format(chars, len);
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 99) < 80) begin
               build_text(chars, len);
            end else begin
               text_q.delete();
               repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 15)
               text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            send_text();
         end
         settle();
      end

      $display("Scanned %0d text bytes in %0d buffers under %0d format settings.",
               bytes_sent, buffers_sent, format_settings);
      $display("Checked %0d scanner results, %0d failures.", results_checked, failure_count);
      if (failure_count == 0) begin
         $display("PASS format_driven_field_scanner_unit");
      end else begin
         $display("FAIL format_driven_field_scanner_unit");
      end
      $finish;
   end

endmodule
`default_nettype wire
